// ----- hw/rtl/rtp_header_checker_core_macros.svh -----
// ----------------------------------------------------------------------------
// RTP header checker assertion macros
// Concurrent assertion wrappers used by the checker RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef RTP_HEADER_CHECKER_CORE_MACROS_SVH
`define RTP_HEADER_CHECKER_CORE_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, disabled while reset is asserted.
`define RHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/rhc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the RTP header checker.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned HdrW      = HdrBytes * 8;
  localparam int unsigned PosW      = 4;

  // byte counter: 0..11 header bytes, 12 = header done, rest of packet ignored
  localparam logic [PosW-1:0] POS_LAST_HDR = PosW'(HdrBytes - 1);
  localparam logic [PosW-1:0] POS_DONE     = PosW'(HdrBytes);

  localparam logic [1:0] RTP_VERSION = 2'd2;

  // event queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // result payload: lost(16) pt(7) seq(16) ts(32) ssrc(32) = 103, padded to 104
  localparam int unsigned OutDataW = 104;
  localparam int unsigned StatusW  = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_HDR    = 3'd2,
    ST_PT_CHANGED = 3'd3,
    ST_OLD        = 3'd4
  } status_t;

  // one verdict request from the front end
  typedef struct packed {
    logic            is_short;
    logic [HdrW-1:0] hdr;       // byte 0 in the top bits
  } hdr_evt_t;

endpackage

// ----- hw/rtl/rhc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front
// Byte intake: counts header bytes, assembles the header, posts verdict events.
// ----------------------------------------------------------------------------
`include "rtp_header_checker_core_macros.svh"

module rhc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             q_full,
  output logic             evt_push,
  output rhc_pkg::hdr_evt_t evt
);
  import rhc_pkg::*;

  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [HdrW-9:0]   hdr_r;
  logic              accept;
  logic              at_last_hdr;

  assign in_tready   = !q_full;
  assign accept      = in_tvalid && in_tready;
  assign at_last_hdr = (pos_r == POS_LAST_HDR);

  // verdict on the 12th byte, or a short-packet event on an early last mark
  assign evt_push     = accept && (at_last_hdr || (in_tlast && (pos_r < POS_LAST_HDR)));
  // {is_short, header with byte 0 on top}
  assign evt          = {!at_last_hdr, hdr_r, in_tdata};

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt = '0;
      end else if (pos_r != POS_DONE) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // 11-byte shift line; a full header always shifts in fresh bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r <= {hdr_r[HdrW-17:0], in_tdata};
    end
  end

  `RHC_ASSERT(a_pos_range, clk, rst_n, pos_r <= POS_DONE, "byte counter out of range")
  `RHC_ASSERT(a_hdr_evt_pos, clk, rst_n, (evt_push && !evt.is_short) |-> (pos_r == POS_LAST_HDR), "header event off the twelfth byte")
  `RHC_ASSERT(a_last_rewind, clk, rst_n, (accept && in_tlast) |=> (pos_r == '0), "counter not rewound after last byte")

endmodule

// ----- hw/rtl/rhc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_fifo
// Small event queue between the byte intake and the verdict stage.
// ----------------------------------------------------------------------------
`include "rtp_header_checker_core_macros.svh"

module rhc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rhc_pkg::hdr_evt_t din,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output rhc_pkg::hdr_evt_t dout
);
  import rhc_pkg::*;

  hdr_evt_t          entry_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == QCntW'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  `RHC_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= QCntW'(QDepth), "queue count above depth")
  `RHC_ASSERT(a_no_drop, clk, rst_n, push |-> !full, "event pushed into full queue")
  `RHC_ASSERT(a_ptr_gap, clk, rst_n, (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r), "pointers disagree on empty queue")

endmodule

// ----- hw/rtl/rhc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back
// Verdict stage: header checks, payload type and timestamp tracking, result reg.
// ----------------------------------------------------------------------------
`include "rtp_header_checker_core_macros.svh"

module rhc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rhc_pkg::hdr_evt_t             q_evt,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rhc_pkg::OutDataW-1:0]  out_tdata,
  output logic [rhc_pkg::StatusW-1:0]   out_tuser
);
  import rhc_pkg::*;

  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  status_t             out_status_r;

  logic                awaiting_first_r;
  logic [6:0]          kept_pt_r;
  logic [15:0]         kept_ts_r;     // only the low half enters the difference

  logic [1:0]          ver;
  logic                ext, mark;
  logic [3:0]          csrc;
  logic [6:0]          pt;
  logic [15:0]         seq;
  logic [31:0]         ts, ssrc;
  logic [15:0]         diff;
  status_t             status;
  logic [15:0]         lost;
  logic                keep;

  assign ver  = q_evt.hdr[95:94];
  assign ext  = q_evt.hdr[92];
  assign csrc = q_evt.hdr[91:88];
  assign mark = q_evt.hdr[87];
  assign pt   = q_evt.hdr[86:80];
  assign seq  = q_evt.hdr[79:64];
  assign ts   = q_evt.hdr[63:32];
  assign ssrc = q_evt.hdr[31:0];
  assign diff = ts[15:0] - kept_ts_r;

  always_comb begin
    status = ST_OK;
    lost   = '0;
    keep   = 1'b0;
    priority if (q_evt.is_short) begin
      status = ST_SHORT;
    end else if (ver != RTP_VERSION || ext || csrc != '0 || mark) begin
      status = ST_BAD_HDR;
    end else if (awaiting_first_r) begin
      keep = 1'b1;
    end else if (pt != kept_pt_r) begin
      status = ST_PT_CHANGED;
    end else if (diff[15]) begin
      // old packet: diff - 65535 modulo 2^16
      status = ST_OLD;
      lost   = diff + 16'd1;
    end else begin
      lost = diff;
      keep = 1'b1;
    end
  end

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      awaiting_first_r <= 1'b1;
      kept_pt_r        <= '0;
      kept_ts_r        <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && keep) begin
        awaiting_first_r <= 1'b0;
        kept_pt_r        <= pt;
        kept_ts_r        <= ts[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_status_r <= status;
      if (q_evt.is_short) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {1'b0, ssrc, ts, seq, pt, lost};
      end
    end
  end

  `RHC_ASSERT(a_short_zero, clk, rst_n, (out_valid_r && out_status_r == ST_SHORT) |-> (out_data_r == '0), "short verdict carries data")
  `RHC_ASSERT(a_first_ok, clk, rst_n, $fell(awaiting_first_r) |-> (out_valid_r && out_status_r == ST_OK && out_data_r[15:0] == '0), "first accepted header not reported clean")
  `RHC_ASSERT(a_pad_zero, clk, rst_n, out_valid_r |-> !out_data_r[OutDataW-1], "pad bit set")

endmodule

// ----- hw/rtl/rtp_header_checker_core.sv -----
`timescale 1ns / 1ps
// RTP header checker. Packet bytes enter one per transaction on the in_ stream
// (network order, in_tlast on the final byte) and one verdict per packet leaves
// on the out_ stream: after the 12th byte, or at the last byte of a shorter
// packet. A byte is accepted every cycle while the event queue has room; a
// verdict passes the event queue and the result register on its way to
// out_tvalid, and one verdict per cycle can drain while out_tready is high,
// so a stream of one-byte packets still runs at one transaction per clock.
// Status codes on out_tuser: 0 ok, 1 too short, 2 bad header (version not 2,
// X, CC or M set), 3 payload type changed, 4 old packet (16-bit timestamp
// step above 32767, lost_count = step - 65535). The first good header and
// every later ok header set the tracked payload type and timestamp; all other
// verdicts leave them unchanged. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// rtp_header_checker_core
// Top level: byte intake, event queue and verdict stage.
// ----------------------------------------------------------------------------

module rtp_header_checker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] byte_data
  input  logic                          in_tlast,   // last_byte
  // verdict stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] lost_count (signed), [22:16] payload_kind, [38:23] sequence_value,
  // [70:39] time_stamp, [102:71] source_id, [103] zero pad
  output logic [rhc_pkg::OutDataW-1:0]  out_tdata,
  output logic [rhc_pkg::StatusW-1:0]   out_tuser   // [2:0] status
);
  import rhc_pkg::*;

  // front -> queue
  logic     evt_push;
  hdr_evt_t evt_in;
  logic     q_full;
  // queue -> back
  logic     q_valid;
  logic     q_pop;
  hdr_evt_t evt_out;

  // Front end: tracks the byte position and builds the 12-byte header.
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .evt_push  (evt_push),
    .evt       (evt_in)
  );

  // Decouples intake from a stalled result side.
  rhc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .din       (evt_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (evt_out)
  );

  // Back end: judges each header and owns the tracked stream state.
  rhc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_evt      (evt_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/tb_rtp_header_checker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtp_header_checker_core
// Self-checking bench for the RTP header checker: a directed packet table, then
// random packet streams, each verdict scored against its typed row or a local model.
// ----------------------------------------------------------------------------
module tb_rtp_header_checker_core;
  import rhc_pkg::*;

  localparam int unsigned HoldCycles    = 300;  // long receiver hold-off
  localparam int unsigned WatchdogLimit = 2000; // cycles without any transaction
  localparam int unsigned DrainCycles   = 8;    // extra wait after the last owed verdict
  localparam int unsigned RandBytes     = 380;
  localparam int unsigned RandPackets   = 24;

  // One verdict, field by field, as carried on out_tuser / out_tdata.
  typedef struct packed {
    status_t     status;
    logic [15:0] lost;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
  } verdict_t;

  // Directed packet: header with byte 0 in the top bits, packet length, and a
  // typed status for the rows whose verdict is obvious. Typed rows always
  // carry lost_count 0; short packets report all-zero fields.
  typedef struct {
    logic [HdrW-1:0] hdr;
    int unsigned     len;
    bit              typed;
    status_t         st;
  } pkt_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // [7:0] byte_data
  logic                in_tlast = 1'b0; // last_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;       // lost, pt, seq, ts, ssrc, pad
  logic [StatusW-1:0]  out_tuser;       // [2:0] status

  always #2 clk = ~clk;

  rtp_header_checker_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Header model state
  // --------------------------------------------------------------------------
  logic            first_pending = 1'b1; // no good header tracked yet
  logic [6:0]      trk_pt = '0;
  logic [31:0]     trk_ts = '0;
  int unsigned     hdr_pos = 0;          // 0..12, holds at 12
  logic [7:0]      hdr_buf [HdrBytes];
  logic            hdr_judged = 1'b0;    // verdict already given for this packet

  verdict_t        verdict_q [$];        // verdicts still owed by the DUT
  int unsigned     mismatches = 0;
  int unsigned     idle_pct = 25;        // idle odds per cycle, both sides
  logic            hold_armed = 1'b0;
  logic            hold_taken = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;

  initial begin
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
  end

  // Judge a complete 12-byte header and update the tracked PT / timestamp.
  function automatic verdict_t judge_header();
    verdict_t    v;
    logic [15:0] step;
    v        = '0;
    v.status = ST_OK;
    v.pt     = hdr_buf[1][6:0];
    v.seq    = {hdr_buf[2], hdr_buf[3]};
    v.ts     = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
    v.ssrc   = {hdr_buf[8], hdr_buf[9], hdr_buf[10], hdr_buf[11]};
    if (hdr_buf[0][7:6] != RTP_VERSION || hdr_buf[0][4] || hdr_buf[0][3:0] != 4'd0 ||
        hdr_buf[1][7]) begin
      v.status = ST_BAD_HDR;
    end else if (first_pending) begin
      first_pending = 1'b0;
      trk_pt        = v.pt;
      trk_ts        = v.ts;
    end else if (v.pt != trk_pt) begin
      v.status = ST_PT_CHANGED;
    end else begin
      step = v.ts[15:0] - trk_ts[15:0];
      if (step > 16'd32767) begin
        // old packet: step - 65535 in 16 bits, tracking left alone
        v.status = ST_OLD;
        v.lost   = step + 16'd1;
      end else begin
        v.lost = step;
        trk_ts = v.ts;
      end
    end
    return v;
  endfunction

  // Feed one accepted byte; returns 1 when it produces a verdict.
  function automatic bit predict_byte(input logic [7:0] b, input logic is_last,
                                      output verdict_t v);
    bit got;
    got = 1'b0;
    v   = '0;
    if (!hdr_judged && hdr_pos < HdrBytes) begin
      hdr_buf[hdr_pos] = b;
      hdr_pos++;
      if (hdr_pos >= HdrBytes) begin
        v          = judge_header();
        hdr_judged = 1'b1;
        got        = 1'b1;
      end
    end
    if (is_last) begin
      if (!hdr_judged) begin
        // packet ended inside the header: all-zero verdict
        v        = '0;
        v.status = ST_SHORT;
        got      = 1'b1;
      end
      hdr_pos    = 0;
      hdr_judged = 1'b0;
      foreach (hdr_buf[i]) hdr_buf[i] = '0;
    end
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // Byte sender. Prediction runs at the edge where a transaction completes.
  // Bytes past the header are random payload.
  // --------------------------------------------------------------------------
  task automatic send_packet(input logic [HdrW-1:0] hdr, input int unsigned len,
                             input bit typed, input verdict_t typed_v);
    logic [7:0] b;
    logic       is_last;
    verdict_t   v;
    for (int unsigned i = 0; i < len; i++) begin
      b       = (i < HdrBytes) ? hdr[HdrW - 1 - 8 * i -: 8] : 8'($urandom);
      is_last = (i == len - 1);
      while ($urandom_range(99) < idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= b;
      in_tlast  <= is_last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (predict_byte(b, is_last, v)) verdict_q.push_back(typed ? typed_v : v);
    end
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Verdict sink: scores every out_ transaction and drives out_tready,
  // including the one long hold-off that backs the byte stream up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : verdict_sink
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.lost   = out_tdata[15:0];
        got.pt     = out_tdata[22:16];
        got.seq    = out_tdata[38:23];
        got.ts     = out_tdata[70:39];
        got.ssrc   = out_tdata[102:71];
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected verdict: status %0d lost %h pt %h seq %h ts %h ssrc %h",
                               got.status, got.lost, got.pt, got.seq, got.ts, got.ssrc));
        end else begin
          want = verdict_q.pop_front();
          if (got.status !== want.status || got.lost !== want.lost || got.pt !== want.pt ||
              got.seq !== want.seq || got.ts !== want.ts || got.ssrc !== want.ssrc) begin
            flag_error($sformatf({"verdict mismatch: exp status %0d lost %h pt %h seq %h ",
                                  "ts %h ssrc %h / got status %0d lost %h pt %h seq %h ",
                                  "ts %h ssrc %h"},
                                 want.status, want.lost, want.pt, want.seq, want.ts,
                                 want.ssrc, got.status, got.lost, got.pt, got.seq,
                                 got.ts, got.ssrc));
          end
        end
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (hold_armed && !hold_taken) begin
        hold_taken <= 1'b1;
        stall_left <= HoldCycles;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: too long without a transaction on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("** rtp_header_checker_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed packets, header laid out as b0_b1_seq_ts_ssrc
  // --------------------------------------------------------------------------
  pkt_row_t pkt_tab [18] = '{
    '{96'hFF_FF_FFFF_FFFFFFFF_FFFFFFFF,  1, 1'b1, ST_SHORT},      // one-byte packet
    '{96'hFF_FF_FFFF_FFFFFFFF_FFFFFFFF, 11, 1'b1, ST_SHORT},      // one byte short
    '{96'h00_00_0000_00000000_00000000, 12, 1'b1, ST_BAD_HDR},    // version 0
    '{96'hFF_FF_FFFF_FFFFFFFF_FFFFFFFF, 12, 1'b1, ST_BAD_HDR},    // all bits set
    '{96'h40_05_1234_00000100_A5A5A5A5, 12, 1'b1, ST_BAD_HDR},    // version 1
    '{96'h90_05_1234_00000100_A5A5A5A5, 12, 1'b1, ST_BAD_HDR},    // extension bit
    '{96'h8F_05_1234_00000100_A5A5A5A5, 12, 1'b1, ST_BAD_HDR},    // CSRC count 15
    '{96'h80_85_1234_00000100_A5A5A5A5, 12, 1'b1, ST_BAD_HDR},    // marker set
    '{96'h80_7F_FFFF_FFFFFFF0_FFFFFFFF, 12, 1'b1, ST_OK},         // first good, tracked
    '{96'h80_00_0000_FFFFFFF0_00000000, 20, 1'b1, ST_PT_CHANGED}, // PT 0, payload after
    '{96'h80_7F_0001_FFFFFFF0_12345678, 13, 1'b1, ST_OK},         // same ts, no loss
    '{96'h80_7F_0002_00007FEF_12345678, 12, 1'b0, ST_OK},         // step 32767, wraps
    '{96'h80_7F_0003_0000FFEF_12345678, 12, 1'b0, ST_OLD},        // step 32768
    '{96'h80_7F_0004_00007FEE_12345678, 16, 1'b0, ST_OLD},        // step 65535
    '{96'h80_7F_0005_00017FF0_87654321, 30, 1'b0, ST_OK},         // upper ts bits ignored
    '{96'h80_7F_0006_00017FF0_87654321,  1, 1'b1, ST_SHORT},      // back-to-back shorts
    '{96'h80_7F_0007_00017FF0_87654321,  5, 1'b1, ST_SHORT},
    '{96'h80_7F_FFFF_00017FF0_00000000, 12, 1'b0, ST_OK}          // zero step again
  };

  initial begin : stimulus
    verdict_t        tv;
    logic [HdrW-1:0] hdr;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [31:0]     ts;
    int unsigned     len;
    int unsigned     pkt_cnt;
    int unsigned     byte_cnt;
    int unsigned     r;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (pkt_tab[i]) begin
      tv        = '0;
      tv.status = pkt_tab[i].st;
      if (pkt_tab[i].st != ST_SHORT) begin
        tv.pt   = pkt_tab[i].hdr[86:80];
        tv.seq  = pkt_tab[i].hdr[79:64];
        tv.ts   = pkt_tab[i].hdr[63:32];
        tv.ssrc = pkt_tab[i].hdr[31:0];
      end
      send_packet(pkt_tab[i].hdr, pkt_tab[i].len, pkt_tab[i].typed, tv);
    end

    // Random part: mostly well-formed headers that follow the tracked PT and
    // timestamp, with bad headers, PT changes, old packets and shorts mixed in.
    pkt_cnt  = 0;
    byte_cnt = 0;
    tv       = '0;
    while (byte_cnt < RandBytes || pkt_cnt < RandPackets) begin
      if (pkt_cnt == 4) hold_armed <= 1'b1;   // receiver backs the stream up
      if (pkt_cnt == 10) idle_pct <= 0;       // stretch with no idling
      if (pkt_cnt == 20) idle_pct <= 25;

      r  = $urandom_range(99);
      b0 = (r < 10) ? 8'($urandom) : 8'h80;
      b1 = {($urandom_range(19) == 0),
            ($urandom_range(99) < 80) ? trk_pt : 7'($urandom_range(127))};

      r = $urandom_range(99);
      if (r < 60)      ts = trk_ts + $urandom_range(4000);
      else if (r < 75) ts = trk_ts + $urandom_range(32760, 32775);
      else if (r < 85) ts = trk_ts - $urandom_range(1, 40000);
      else             ts = $urandom;

      r = $urandom_range(99);
      if (r < 12)      len = $urandom_range(1, HdrBytes - 1);
      else if (r < 97) len = $urandom_range(HdrBytes, HdrBytes + 6);
      else             len = $urandom_range(40, 64);

      hdr = {b0, b1, 16'($urandom), ts, 32'($urandom)};
      send_packet(hdr, len, 1'b0, tv);
      pkt_cnt++;
      byte_cnt += len;
    end
    in_tvalid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("** rtp_header_checker_core: PASSED **");
    end else begin
      $display("** rtp_header_checker_core: FAILED **");
    end
    $finish;
  end

endmodule
